FILE: hw/rtl/assert_macros.svh
// assertion helpers, clocked on clk and disabled while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition implies consequence in the same cycle
`define ASSERT_SAME(label, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// condition implies consequence in the next cycle
`define ASSERT_NEXT(label, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

FILE: hw/rtl/rp3d_pkg.sv
// ----------------------------------------------------------------------------
// rp3d_pkg
// shared widths, word types and cordic constants of the euler point rotator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rp3d_pkg;

	localparam int COORD_WIDTH    = 32;
	localparam int ANGLE_WIDTH    = 16;
	localparam int TRIG_FRAC_BITS = 15;

	localparam int CORDIC_ITERS = 30;
	localparam int CORDIC_FRAC  = 30;
	localparam int CORDIC_W     = 34;
	localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] point_x;
		logic signed [COORD_WIDTH-1:0] point_y;
		logic signed [COORD_WIDTH-1:0] point_z;
		logic signed [COORD_WIDTH-1:0] pivot_x;
		logic signed [COORD_WIDTH-1:0] pivot_y;
		logic signed [COORD_WIDTH-1:0] pivot_z;
		logic signed [ANGLE_WIDTH-1:0] yaw_angle;
		logic signed [ANGLE_WIDTH-1:0] pitch_angle;
		logic signed [ANGLE_WIDTH-1:0] roll_angle;
	} in_word_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] rotated_x;
		logic signed [COORD_WIDTH-1:0] rotated_y;
		logic signed [COORD_WIDTH-1:0] rotated_z;
	} out_word_t;

	// arctangent of 2^-i in units of 2^-32 turn
	function automatic logic signed [CORDIC_W-1:0] atan_turn(input int i);
		logic signed [CORDIC_W-1:0] r;
		r = '0;
		case (i)
			0:  r = 34'sd536870912;
			1:  r = 34'sd316933406;
			2:  r = 34'sd167458907;
			3:  r = 34'sd85004756;
			4:  r = 34'sd42667331;
			5:  r = 34'sd21354465;
			6:  r = 34'sd10679838;
			7:  r = 34'sd5340245;
			8:  r = 34'sd2670163;
			9:  r = 34'sd1335087;
			10: r = 34'sd667544;
			11: r = 34'sd333772;
			12: r = 34'sd166886;
			13: r = 34'sd83443;
			14: r = 34'sd41722;
			15: r = 34'sd20861;
			16: r = 34'sd10430;
			17: r = 34'sd5215;
			18: r = 34'sd2608;
			19: r = 34'sd1304;
			20: r = 34'sd652;
			21: r = 34'sd326;
			22: r = 34'sd163;
			23: r = 34'sd81;
			24: r = 34'sd41;
			25: r = 34'sd20;
			26: r = 34'sd10;
			27: r = 34'sd5;
			28: r = 34'sd3;
			29: r = 34'sd1;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

FILE: hw/rtl/rp3d_dly.sv
// ----------------------------------------------------------------------------
// rp3d_dly
// enabled delay line that keeps payload aligned with the pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rp3d_dly #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1
) (
	input  logic             clk,
	input  logic             en,
	input  logic [WIDTH-1:0] din,
	output logic [WIDTH-1:0] dout
);

	logic [WIDTH-1:0] tap_q [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (en) begin
			tap_q[0] <= din;
			for (int k = 1; k < DEPTH; k++) begin
				tap_q[k] <= tap_q[k-1];
			end
		end
	end

	assign dout = tap_q[DEPTH-1];

endmodule

FILE: hw/rtl/rp3d_sincos.sv
// ----------------------------------------------------------------------------
// rp3d_sincos
// pipelined rotation-mode cordic, one iteration per stage, gives cos and sin
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rp3d_sincos #(
	parameter int TRIG_FRAC_BITS = rp3d_pkg::TRIG_FRAC_BITS
) (
	input  logic                                    clk,
	input  logic                                    en,
	input  logic signed [rp3d_pkg::ANGLE_WIDTH-1:0] angle,
	output logic signed [TRIG_FRAC_BITS+1:0]        cos_o,
	output logic signed [TRIG_FRAC_BITS+1:0]        sin_o,
	output logic                                    zero_o
);
	import rp3d_pkg::*;

	localparam int TW = TRIG_FRAC_BITS + 2;
	localparam int NS = CORDIC_ITERS;
	localparam logic signed [CORDIC_W-1:0] QUARTER = 34'sh040000000;
	localparam logic signed [CORDIC_W-1:0] HALF    = 34'sh080000000;
	localparam logic signed [CORDIC_W-1:0] RND =
		CORDIC_W'(1) <<< (CORDIC_FRAC - 1 - TRIG_FRAC_BITS);

	logic signed [CORDIC_W-1:0] x_q [0:NS];
	logic signed [CORDIC_W-1:0] y_q [0:NS];
	logic signed [CORDIC_W-1:0] z_q [0:NS];
	logic                       neg_q [0:NS];
	logic                       zero_q [0:NS];

	logic signed [CORDIC_W-1:0] z_in;
	logic signed [CORDIC_W-1:0] x_rnd, y_rnd, x_sh, y_sh;
	logic signed [TW-1:0]       cos_s, sin_s;

	// angle sits in the top bits of a 32-bit turn
	assign z_in = CORDIC_W'($signed({angle, {(32-ANGLE_WIDTH){1'b0}}}));

	// fold into [-90, +90] degrees
	always_ff @(posedge clk) begin
		if (en) begin
			x_q[0]    <= CORDIC_GAIN;
			y_q[0]    <= '0;
			zero_q[0] <= (angle == '0);
			if (z_in > QUARTER) begin
				z_q[0]   <= z_in - HALF;
				neg_q[0] <= 1'b1;
			end else if (z_in < -QUARTER) begin
				z_q[0]   <= z_in + HALF;
				neg_q[0] <= 1'b1;
			end else begin
				z_q[0]   <= z_in;
				neg_q[0] <= 1'b0;
			end
		end
	end

	for (genvar k = 0; k < NS; k++) begin : g_iter
		always_ff @(posedge clk) begin
			if (en) begin
				neg_q[k+1]  <= neg_q[k];
				zero_q[k+1] <= zero_q[k];
				if (!z_q[k][CORDIC_W-1]) begin
					x_q[k+1] <= x_q[k] - (y_q[k] >>> k);
					y_q[k+1] <= y_q[k] + (x_q[k] >>> k);
					z_q[k+1] <= z_q[k] - atan_turn(k);
				end else begin
					x_q[k+1] <= x_q[k] + (y_q[k] >>> k);
					y_q[k+1] <= y_q[k] - (x_q[k] >>> k);
					z_q[k+1] <= z_q[k] + atan_turn(k);
				end
			end
		end
	end

	// round half up to the trig fraction, then undo the fold
	always_comb begin
		x_rnd = x_q[NS] + RND;
		y_rnd = y_q[NS] + RND;
		x_sh  = x_rnd >>> (CORDIC_FRAC - TRIG_FRAC_BITS);
		y_sh  = y_rnd >>> (CORDIC_FRAC - TRIG_FRAC_BITS);
		cos_s = neg_q[NS] ? -x_sh[TW-1:0] : x_sh[TW-1:0];
		sin_s = neg_q[NS] ? -y_sh[TW-1:0] : y_sh[TW-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cos_o  <= cos_s;
			sin_o  <= sin_s;
			zero_o <= zero_q[NS];
		end
	end

endmodule

FILE: hw/rtl/rp3d_rot.sv
// ----------------------------------------------------------------------------
// rp3d_rot
// two-stage plane rotation of a coordinate pair: products, then sum and round
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rp3d_rot #(
	parameter int TRIG_FRAC_BITS = rp3d_pkg::TRIG_FRAC_BITS
) (
	input  logic                                    clk,
	input  logic                                    en,
	input  logic signed [rp3d_pkg::COORD_WIDTH-1:0] a,
	input  logic signed [rp3d_pkg::COORD_WIDTH-1:0] b,
	input  logic signed [TRIG_FRAC_BITS+1:0]        c,
	input  logic signed [TRIG_FRAC_BITS+1:0]        s,
	input  logic                                    zero,
	output logic signed [rp3d_pkg::COORD_WIDTH-1:0] a_o,
	output logic signed [rp3d_pkg::COORD_WIDTH-1:0] b_o
);
	import rp3d_pkg::*;

	localparam int CW = COORD_WIDTH;
	localparam int TW = TRIG_FRAC_BITS + 2;
	localparam int PW = CW + TW;
	localparam int SW = PW + 1;
	localparam logic signed [SW-1:0] HALF = SW'(1) <<< (TRIG_FRAC_BITS - 1);

	logic signed [PW-1:0] ca_s1, sb_s1, cb_s1, sa_s1;
	logic signed [CW-1:0] a_s1, b_s1;
	logic                 zero_s1;
	logic signed [SW-1:0] na_sum, nb_sum;

	always_ff @(posedge clk) begin
		if (en) begin
			ca_s1   <= PW'(c) * PW'(a);
			sb_s1   <= PW'(s) * PW'(b);
			cb_s1   <= PW'(c) * PW'(b);
			sa_s1   <= PW'(s) * PW'(a);
			a_s1    <= a;
			b_s1    <= b;
			zero_s1 <= zero;
		end
	end

	assign na_sum = SW'(ca_s1) - SW'(sb_s1) + HALF;
	assign nb_sum = SW'(cb_s1) + SW'(sa_s1) + HALF;

	// zero angle passes the pair through untouched
	always_ff @(posedge clk) begin
		if (en) begin
			a_o <= zero_s1 ? a_s1 : na_sum[TRIG_FRAC_BITS+CW-1:TRIG_FRAC_BITS];
			b_o <= zero_s1 ? b_s1 : nb_sum[TRIG_FRAC_BITS+CW-1:TRIG_FRAC_BITS];
		end
	end

endmodule

FILE: hw/rtl/rotate_point_3d_euler_unit.sv
// ----------------------------------------------------------------------------
// rotate_point_3d_euler_unit
// rotates a point about a pivot by yaw, pitch and roll
// ----------------------------------------------------------------------------
// usage: words enter on in_data under in_valid/in_ready and leave on out_data
// under out_valid/out_ready. each word holds a point, a pivot and three binary
// angles; the result is the point turned in the x-z plane (yaw), then the y-z
// plane (pitch), then the y-x plane (roll), about the pivot, wrapping.
// a word passes from acceptance to out_valid through the pipelined cordic
// (fold, 30 iterations, rounding), each plane rotation (multiply, then sum
// and round) and the pivot add-back. throughput is one word per cycle while
// the output does not stall; the three angles have cordic units of
// their own and every plane rotation has its own four multipliers.
// the whole pipeline advances together: while out_valid is high and
// out_ready low, in_ready drops and every stage holds its word.
// reset clears the valid bits only; the pipeline comes up empty and ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rotate_point_3d_euler_unit #(
	parameter int TRIG_FRAC_BITS = rp3d_pkg::TRIG_FRAC_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  rp3d_pkg::in_word_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output rp3d_pkg::out_word_t out_data
);
	import rp3d_pkg::*;
	`include "assert_macros.svh"

	localparam int CW    = COORD_WIDTH;
	localparam int TW    = TRIG_FRAC_BITS + 2;
	localparam int TRIG_LAT = CORDIC_ITERS + 2;
	localparam int ROT_LAT  = 2;
	localparam int NSTAGE   = TRIG_LAT + 3 * ROT_LAT + 1;

	logic              adv;
	logic [NSTAGE-1:0] vld_q;

	logic signed [CW-1:0] rel_x, rel_y, rel_z;
	logic signed [CW-1:0] dx, dy, dz;
	logic [3*CW-1:0]      piv_d;
	logic signed [CW-1:0] px_d, py_d, pz_d;

	logic signed [TW-1:0] yc, ys, pc0, ps0, rc0, rs0, pc, ps, rc, rs;
	logic                 yz, pz0, rz0, pzr, rzr;

	logic signed [CW-1:0] x1, z1, y2, z2, y3, x3;
	logic signed [CW-1:0] z2_d;
	logic signed [CW-1:0] z1_d, x1_d;

	assign adv       = !vld_q[NSTAGE-1] || out_ready;
	assign in_ready  = adv;
	assign out_valid = vld_q[NSTAGE-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NSTAGE-2:0], in_valid};
		end
	end

	assign rel_x = in_data.point_x - in_data.pivot_x;
	assign rel_y = in_data.point_y - in_data.pivot_y;
	assign rel_z = in_data.point_z - in_data.pivot_z;

	rp3d_sincos #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_yaw_trig (
		.clk(clk), .en(adv), .angle(in_data.yaw_angle),
		.cos_o(yc), .sin_o(ys), .zero_o(yz)
	);
	rp3d_sincos #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_pitch_trig (
		.clk(clk), .en(adv), .angle(in_data.pitch_angle),
		.cos_o(pc0), .sin_o(ps0), .zero_o(pz0)
	);
	rp3d_sincos #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_roll_trig (
		.clk(clk), .en(adv), .angle(in_data.roll_angle),
		.cos_o(rc0), .sin_o(rs0), .zero_o(rz0)
	);

	rp3d_dly #(.WIDTH(3*CW), .DEPTH(TRIG_LAT)) u_rel_dly (
		.clk(clk), .en(adv), .din({rel_x, rel_y, rel_z}), .dout({dx, dy, dz})
	);
	rp3d_dly #(.WIDTH(3*CW), .DEPTH(NSTAGE-1)) u_piv_dly (
		.clk(clk), .en(adv),
		.din({in_data.pivot_x, in_data.pivot_y, in_data.pivot_z}), .dout(piv_d)
	);
	assign {px_d, py_d, pz_d} = piv_d;

	// pitch trig waits for yaw, roll trig for yaw and pitch
	rp3d_dly #(.WIDTH(2*TW+1), .DEPTH(ROT_LAT)) u_pitch_dly (
		.clk(clk), .en(adv), .din({pc0, ps0, pz0}), .dout({pc, ps, pzr})
	);
	rp3d_dly #(.WIDTH(2*TW+1), .DEPTH(2*ROT_LAT)) u_roll_dly (
		.clk(clk), .en(adv), .din({rc0, rs0, rz0}), .dout({rc, rs, rzr})
	);

	// untouched coordinates ride alongside each plane rotation
	logic signed [CW-1:0] y_d;
	rp3d_dly #(.WIDTH(CW), .DEPTH(ROT_LAT)) u_y_dly (
		.clk(clk), .en(adv), .din(dy), .dout(y_d)
	);
	rp3d_dly #(.WIDTH(CW), .DEPTH(ROT_LAT)) u_x_dly (
		.clk(clk), .en(adv), .din(x1), .dout(x1_d)
	);
	rp3d_dly #(.WIDTH(CW), .DEPTH(ROT_LAT)) u_z_dly (
		.clk(clk), .en(adv), .din(z2), .dout(z2_d)
	);

	rp3d_rot #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_yaw (
		.clk(clk), .en(adv), .a(dx), .b(dz), .c(yc), .s(ys), .zero(yz),
		.a_o(x1), .b_o(z1)
	);
	assign z1_d = z1;
	rp3d_rot #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_pitch (
		.clk(clk), .en(adv), .a(y_d), .b(z1_d), .c(pc), .s(ps), .zero(pzr),
		.a_o(y2), .b_o(z2)
	);
	rp3d_rot #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_roll (
		.clk(clk), .en(adv), .a(y2), .b(x1_d), .c(rc), .s(rs), .zero(rzr),
		.a_o(y3), .b_o(x3)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data.rotated_x <= x3 + px_d;
			out_data.rotated_y <= y3 + py_d;
			out_data.rotated_z <= z2_d + pz_d;
		end
	end

	`ASSERT_SAME(a_ready_only_on_stall, !in_ready, out_valid && !out_ready)
	`ASSERT_NEXT(a_accept_enters, in_valid && in_ready, vld_q[0])
	`ASSERT_NEXT(a_stall_freezes, out_valid && !out_ready, $stable(vld_q))

endmodule

FILE: dv/rotate_point_3d_euler_checker.sv
// ----------------------------------------------------------------------------
// rotate_point_3d_euler_checker
// watches both channels of the euler point rotator, predicts each rotated
// point from the accepted input word and compares it with the output words
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rotate_point_3d_euler_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  rp3d_pkg::in_word_t  in_data,
	input  logic                out_valid,
	input  logic                out_ready,
	input  rp3d_pkg::out_word_t out_data,
	output int                  errors,
	output int                  pending
);
	import rp3d_pkg::*;

	localparam longint ATAN_TBL [CORDIC_ITERS] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
		83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
		81, 41, 20, 10, 5, 3, 1
	};

	out_word_t rotated_q[$];

	// cosine and sine of a binary angle, TRIG_FRAC_BITS fraction bits
	task automatic trig_of(input logic [ANGLE_WIDTH-1:0] ang, output longint c,
			output longint s);
		logic [31:0] turn;
		longint z, x, y, nx;
		bit flip;
		turn = {ang, {(32-ANGLE_WIDTH){1'b0}}};
		z = longint'($signed(turn));
		x = CORDIC_GAIN;
		y = 0;
		flip = 0;
		// fold into the right half plane
		if (z > 64'sh40000000) begin
			z = z - 64'sh80000000;
			flip = 1;
		end else if (z < -64'sh40000000) begin
			z = z + 64'sh80000000;
			flip = 1;
		end
		for (int i = 0; i < CORDIC_ITERS; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z = z - ATAN_TBL[i];
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z = z + ATAN_TBL[i];
			end
			x = nx;
		end
		x = (x + (64'sd1 << (CORDIC_FRAC-1-TRIG_FRAC_BITS))) >>> (CORDIC_FRAC-TRIG_FRAC_BITS);
		y = (y + (64'sd1 << (CORDIC_FRAC-1-TRIG_FRAC_BITS))) >>> (CORDIC_FRAC-TRIG_FRAC_BITS);
		c = flip ? -x : x;
		s = flip ? -y : y;
	endtask

	task automatic plane_turn(input logic [ANGLE_WIDTH-1:0] ang,
			inout logic signed [COORD_WIDTH-1:0] a, inout logic signed [COORD_WIDTH-1:0] b);
		longint c, s, na, nb;
		if (ang != '0) begin
			trig_of(ang, c, s);
			na = (c * longint'(a) - s * longint'(b) + (64'sd1 << (TRIG_FRAC_BITS-1)))
				>>> TRIG_FRAC_BITS;
			nb = (c * longint'(b) + s * longint'(a) + (64'sd1 << (TRIG_FRAC_BITS-1)))
				>>> TRIG_FRAC_BITS;
			a = na[COORD_WIDTH-1:0];
			b = nb[COORD_WIDTH-1:0];
		end
	endtask

	task automatic rotate_point(input in_word_t w, output out_word_t r);
		logic signed [COORD_WIDTH-1:0] rx, ry, rz;
		rx = w.point_x - w.pivot_x;
		ry = w.point_y - w.pivot_y;
		rz = w.point_z - w.pivot_z;
		plane_turn(w.yaw_angle, rx, rz);
		plane_turn(w.pitch_angle, ry, rz);
		plane_turn(w.roll_angle, ry, rx);
		r.rotated_x = rx + w.pivot_x;
		r.rotated_y = ry + w.pivot_y;
		r.rotated_z = rz + w.pivot_z;
	endtask

	always @(posedge clk) begin
		out_word_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				rotate_point(in_data, want);
				rotated_q.push_back(want);
			end
			if (out_valid && out_ready) begin
				if (rotated_q.size() == 0) begin
					$display("%0t: unexpected word %h", $time, out_data);
					errors++;
				end else begin
					want = rotated_q.pop_front();
					if (out_data.rotated_x !== want.rotated_x) begin
						$display("%0t: x expected %h actual %h", $time, want.rotated_x,
							out_data.rotated_x);
						errors++;
					end
					if (out_data.rotated_y !== want.rotated_y) begin
						$display("%0t: y expected %h actual %h", $time, want.rotated_y,
							out_data.rotated_y);
						errors++;
					end
					if (out_data.rotated_z !== want.rotated_z) begin
						$display("%0t: z expected %h actual %h", $time, want.rotated_z,
							out_data.rotated_z);
						errors++;
					end
				end
			end
			pending = rotated_q.size();
		end
	end

endmodule

FILE: dv/rotate_point_3d_euler_unit_test.sv
// ----------------------------------------------------------------------------
// rotate_point_3d_euler_unit_test
// drives directed and random points, pivots and angles into the rotator with
// random idling on both channels; the checker predicts and compares
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rotate_point_3d_euler_unit_test;
	import rp3d_pkg::*;

	localparam int N_RANDOM = 1200;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_word_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_word_t out_data;
	int        errors;
	int        pending;
	bit        calm;

	rotate_point_3d_euler_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	rotate_point_3d_euler_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.errors(errors), .pending(pending)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("tb: failure");
		$finish;
	end

	// receiver stalls in bursts
	initial begin
		out_ready = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 3) == 0) begin
				out_ready <= 0;
				repeat ($urandom_range(1, 15) - 1) @(posedge clk);
			end else begin
				out_ready <= 1;
				repeat ($urandom_range(1, 30) - 1) @(posedge clk);
			end
		end
	end

	task automatic send_word(input in_word_t w);
		if (!calm && $urandom_range(0, 4) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		in_valid <= 1;
		in_data <= w;
		do @(posedge clk); while (!in_ready);
	endtask

	function automatic logic [ANGLE_WIDTH-1:0] pick_angle();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return 16'sd16384;
			2: return -16'sd16384;
			3: return 16'h8000;
			4: return 16'sd16384 + 16'($urandom_range(0, 2)) - 16'd1;
			5: return 16'($urandom_range(0, 64)) - 16'd32;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [COORD_WIDTH-1:0] pick_coord(input bit near);
		if (near) return 32'($urandom_range(0, 32'h00400000)) - 32'h00200000;
		return $urandom;
	endfunction

	function automatic in_word_t make_word(input bit near, input bit origin);
		in_word_t w;
		w.point_x = pick_coord(near);
		w.point_y = pick_coord(near);
		w.point_z = pick_coord(near);
		w.pivot_x = origin ? '0 : pick_coord(near);
		w.pivot_y = origin ? '0 : pick_coord(near);
		w.pivot_z = origin ? '0 : pick_coord(near);
		w.yaw_angle = pick_angle();
		w.pitch_angle = pick_angle();
		w.roll_angle = pick_angle();
		return w;
	endfunction

	function automatic in_word_t fixed_word(input logic [31:0] p, input logic [31:0] q,
			input logic [15:0] yaw, input logic [15:0] pitch, input logic [15:0] roll);
		return '{p, p + 32'h00010000, p - 32'h00030000, q, q, q, yaw, pitch, roll};
	endfunction

	initial begin
		in_word_t w;
		in_valid = 0;
		in_data = '0;
		calm = 0;
		arst_n = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: extremes of fields, each plane alone, fold boundaries
		send_word('0);
		send_word('1);
		send_word('{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
			32'h80000000, 32'h80000000, 16'h7fff, 16'h7fff, 16'h7fff});
		send_word('{32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff,
			32'h7fffffff, 32'h7fffffff, 16'h8000, 16'h8000, 16'h8000});
		send_word(fixed_word(32'h00050000, 32'h0, 16'h4000, 16'h0, 16'h0));
		send_word(fixed_word(32'h00050000, 32'h0, 16'h0, 16'h4000, 16'h0));
		send_word(fixed_word(32'h00050000, 32'h0, 16'h0, 16'h0, 16'h4000));
		send_word(fixed_word(32'h00050000, 32'h00020000, 16'hc000, 16'h0, 16'h0));
		send_word(fixed_word(32'h00050000, 32'h0, 16'h4001, 16'hbfff, 16'h8000));
		send_word(fixed_word(32'hfffb0000, 32'h0, 16'h0001, 16'hffff, 16'h2000));
		send_word(fixed_word(32'h12345678, 32'h87654321, 16'h1555, 16'h2aaa, 16'h7000));
		send_word(fixed_word(32'h7fff0000, 32'h80010000, 16'h4000, 16'h4000, 16'h4000));
		send_word(fixed_word(32'h0, 32'h00010000, 16'h0, 16'h0, 16'h0));
		send_word(fixed_word(32'h40000000, 32'hc0000000, 16'h8001, 16'h3fff, 16'hc001));

		for (int n = 0; n < N_RANDOM; n++) begin
			if (n == N_RANDOM / 2) begin
				// let the pipeline drain completely once
				in_valid <= 0;
				@(posedge clk);
				while (pending != 0) @(posedge clk);
			end
			if (n == N_RANDOM * 7 / 8) calm = 1;
			w = make_word(1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0);
			send_word(w);
		end
		in_valid <= 0;

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
